@@ rtl/core/tcw_pkg.sv @@
`default_nettype none

package tcw_pkg;

  // Default screen geometry.
  localparam int ROWS_DEF = 25;
  localparam int COLS_DEF = 80;

  // Widths of the payload fields.
  localparam int ACTION_W    = 2;
  localparam int CHAR_W      = 8;
  localparam int COLOR_W     = 8;
  localparam int CELL_W      = CHAR_W + COLOR_W;
  localparam int CELL_ROW_W  = 5;
  localparam int CELL_COL_W  = 7;
  localparam int CUR_ROW_W   = 5;
  localparam int CUR_COL_W   = 7;

  // Configuration port.
  localparam int APB_ADDR_W = 2;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-1:0] REG_TEXT_COLOR = 2'd0;
  localparam logic [COLOR_W-1:0] TEXT_COLOR_RST = 8'd15;

  // Action codes.
  localparam logic [ACTION_W-1:0] ACT_PRINT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

  // Control characters.
  localparam logic [CHAR_W-1:0] CH_LF = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR = 8'h0D;

  // One result item as it travels from the controller to the output register.
  typedef struct packed {
    logic                  serial_valid;
    logic [CHAR_W-1:0]     serial_byte;
    logic [CHAR_W-1:0]     read_char;
    logic [COLOR_W-1:0]    read_color;
    logic [CUR_ROW_W-1:0]  cursor_row;
    logic [CUR_COL_W-1:0]  cursor_col;
    logic                  last;
  } tcw_result_t;

endpackage

`default_nettype wire

@@ rtl/core/tcw_screen_ram.sv @@
`default_nettype none

module tcw_screen_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  wire logic                      clk_i,
  input  wire logic                      we_i,
  input  wire logic                      re_i,
  input  wire logic [AW-1:0]             addr_i,
  input  wire logic [tcw_pkg::CELL_W-1:0] wdata_i,
  output logic      [tcw_pkg::CELL_W-1:0] rdata_o
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] mem_q [DEPTH];

  // Single-port store: one write or one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/tcw_ctrl.sv @@
`default_nettype none

module tcw_ctrl #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [tcw_pkg::ACTION_W-1:0]    action_i,
  input  wire logic [tcw_pkg::CHAR_W-1:0]      char_code_i,
  input  wire logic [tcw_pkg::CELL_ROW_W-1:0]  cell_row_i,
  input  wire logic [tcw_pkg::CELL_COL_W-1:0]  cell_col_i,
  input  wire logic [tcw_pkg::COLOR_W-1:0]     text_color_i,
  output logic                                 res_valid_o,
  input  wire logic                            res_ready_i,
  output tcw_pkg::tcw_result_t                 res_o
);
  import tcw_pkg::*;

  localparam int DEPTH = ROWS * COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int PRW   = $clog2(ROWS);
  localparam int RW    = $clog2(ROWS + 1);
  localparam int CW    = $clog2(COLS + 1);
  localparam int CIW   = $clog2(COLS);

  localparam logic [AW-1:0]  COLS_A     = AW'(COLS);
  localparam logic [AW-1:0]  LAST_ADDR  = AW'(DEPTH - 1);
  localparam logic [CIW-1:0] LAST_COL   = CIW'(COLS - 1);
  localparam logic [PRW-1:0] LAST_ROW   = PRW'(ROWS - 1);
  localparam logic [RW-1:0]  ROWS_R     = RW'(ROWS);
  localparam logic [CW-1:0]  COLS_C     = CW'(COLS);

  // Sequencer states.
  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_SCROLL  = 4'd2;
  localparam logic [3:0] S_WRITE   = 4'd3;
  localparam logic [3:0] S_RD_ADDR = 4'd4;
  localparam logic [3:0] S_RD_DATA = 4'd5;
  localparam logic [3:0] S_EMIT_CR = 4'd6;
  localparam logic [3:0] S_EMIT    = 4'd7;

  // Logical row plus ring base gives the physical row; the sum stays below 2*ROWS.
  function automatic logic [AW-1:0] cell_addr(input logic [PRW-1:0] row,
                                               input logic [PRW-1:0] base,
                                               input logic [CIW-1:0] col);
    logic [PRW:0] sum;
    logic [PRW-1:0] prow;
    sum = {1'b0, row} + {1'b0, base};
    if (sum >= (PRW+1)'(ROWS)) begin
      sum = sum - (PRW+1)'(ROWS);
    end
    prow = sum[PRW-1:0];
    return AW'(prow) * COLS_A + AW'(col);
  endfunction

  logic [3:0]           state_q, state_d;
  logic [PRW-1:0]       cur_row_q, cur_row_d;
  logic [CW-1:0]        cur_col_q, cur_col_d;
  logic [PRW-1:0]       base_q, base_d;
  logic [1:0]           nscroll_q, nscroll_d;
  logic [AW-1:0]        sweep_q, sweep_d;
  logic [CIW-1:0]       col_cnt_q, col_cnt_d;
  logic                 clr_emit_q, clr_emit_d;

  logic                 nl_q, nl_d;
  logic [CHAR_W-1:0]    char_q, char_d;
  logic [PRW-1:0]       wr_row_q, wr_row_d;
  logic [CIW-1:0]       wr_col_q, wr_col_d;
  logic [CELL_ROW_W-1:0] rd_row_q, rd_row_d;
  logic [CELL_COL_W-1:0] rd_col_q, rd_col_d;
  logic                 rd_ok_q, rd_ok_d;
  tcw_result_t          pend_q, pend_d;

  logic                 accept;
  logic                 res_take;
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_addr;
  logic [CELL_W-1:0]    mem_wdata;
  logic [CELL_W-1:0]    mem_rdata;

  // Cursor arithmetic for a print.
  logic                 wrap, s1, s2, is_nl;
  logic [RW-1:0]        r1w, r2w;
  logic [CW-1:0]        c1w, c1;
  logic [PRW-1:0]       r1, r2, fin_row;
  logic [CW-1:0]        fin_col;
  logic [PRW-1:0]       base_inc;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign res_take   = res_valid_o && res_ready_i;
  assign base_inc   = (base_q == LAST_ROW) ? '0 : base_q + PRW'(1);

  // Wrap, optional scroll, then newline with its own optional scroll.
  always_comb begin
    is_nl = (char_code_i == CH_LF) || (char_code_i == CH_CR);
    wrap  = (cur_col_q >= COLS_C);
    r1w   = wrap ? RW'(cur_row_q) + RW'(1) : RW'(cur_row_q);
    c1w   = wrap ? '0 : cur_col_q;
    s1    = (r1w >= ROWS_R);
    r1    = s1 ? LAST_ROW : PRW'(r1w);
    c1    = s1 ? '0 : c1w;
    r2w   = RW'(r1) + RW'(1);
    s2    = is_nl && (r2w >= ROWS_R);
    r2    = s2 ? LAST_ROW : PRW'(r2w);
    fin_row = is_nl ? r2 : r1;
    fin_col = is_nl ? '0 : c1 + CW'(1);
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_d    = state_q;
    cur_row_d  = cur_row_q;
    cur_col_d  = cur_col_q;
    base_d     = base_q;
    nscroll_d  = nscroll_q;
    sweep_d    = sweep_q;
    col_cnt_d  = col_cnt_q;
    clr_emit_d = clr_emit_q;
    nl_d       = nl_q;
    char_d     = char_q;
    wr_row_d   = wr_row_q;
    wr_col_d   = wr_col_q;
    rd_row_d   = rd_row_q;
    rd_col_d   = rd_col_q;
    rd_ok_d    = rd_ok_q;
    pend_d     = pend_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = sweep_q;
    mem_wdata  = '0;
    res_valid_o = 1'b0;
    res_o      = pend_q;

    unique case (state_q)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = sweep_q;
        sweep_d  = sweep_q + AW'(1);
        if (sweep_q == LAST_ADDR) begin
          sweep_d = '0;
          base_d  = '0;
          state_d = clr_emit_q ? S_EMIT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          pend_d = '0;
          pend_d.cursor_row = CUR_ROW_W'(cur_row_q);
          pend_d.cursor_col = CUR_COL_W'(cur_col_q);
          pend_d.last = 1'b1;
          unique case (action_i)
            ACT_PRINT: begin
              cur_row_d = fin_row;
              cur_col_d = fin_col;
              nl_d      = is_nl;
              char_d    = char_code_i;
              wr_row_d  = r1;
              wr_col_d  = CIW'(c1);
              nscroll_d = {1'b0, s1} + {1'b0, s2};
              col_cnt_d = '0;
              pend_d.cursor_row = CUR_ROW_W'(fin_row);
              pend_d.cursor_col = CUR_COL_W'(fin_col);
              pend_d.serial_valid = 1'b1;
              pend_d.serial_byte  = is_nl ? CH_LF : char_code_i;
              if (s1 || s2) begin
                state_d = S_SCROLL;
              end else if (is_nl) begin
                state_d = S_EMIT_CR;
              end else begin
                state_d = S_WRITE;
              end
            end
            ACT_CLEAR: begin
              sweep_d    = '0;
              clr_emit_d = 1'b1;
              state_d    = S_CLEAR;
            end
            ACT_READ: begin
              rd_row_d = cell_row_i;
              rd_col_d = cell_col_i;
              rd_ok_d  = (int'(cell_row_i) < ROWS) && (int'(cell_col_i) < COLS);
              state_d  = S_RD_ADDR;
            end
            default: begin
              state_d = S_EMIT;
            end
          endcase
        end
      end
      S_SCROLL: begin
        // The top physical row becomes the new bottom row and is blanked.
        mem_we    = 1'b1;
        mem_addr  = AW'(base_q) * COLS_A + AW'(col_cnt_q);
        col_cnt_d = col_cnt_q + CIW'(1);
        if (col_cnt_q == LAST_COL) begin
          col_cnt_d = '0;
          base_d    = base_inc;
          nscroll_d = nscroll_q - 2'd1;
          if (nscroll_q == 2'd1) begin
            state_d = nl_q ? S_EMIT_CR : S_WRITE;
          end
        end
      end
      S_WRITE: begin
        // Store the cell and offer the echo; rewriting while stalled is harmless.
        mem_we      = 1'b1;
        mem_addr    = cell_addr(wr_row_q, base_q, wr_col_q);
        mem_wdata   = {text_color_i, char_q};
        res_valid_o = 1'b1;
        if (res_take) begin
          state_d = S_IDLE;
        end
      end
      S_RD_ADDR: begin
        mem_re   = 1'b1;
        mem_addr = cell_addr(PRW'(rd_row_q), base_q, CIW'(rd_col_q));
        state_d  = S_RD_DATA;
      end
      S_RD_DATA: begin
        res_valid_o = 1'b1;
        res_o.read_char  = rd_ok_q ? mem_rdata[CHAR_W-1:0] : '0;
        res_o.read_color = rd_ok_q ? mem_rdata[CELL_W-1:CHAR_W] : '0;
        if (res_take) begin
          state_d = S_IDLE;
        end
      end
      S_EMIT_CR: begin
        res_valid_o = 1'b1;
        res_o.serial_byte = CH_CR;
        res_o.last        = 1'b0;
        if (res_take) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        res_valid_o = 1'b1;
        if (res_take) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      cur_row_q  <= '0;
      cur_col_q  <= '0;
      base_q     <= '0;
      nscroll_q  <= '0;
      sweep_q    <= '0;
      col_cnt_q  <= '0;
      clr_emit_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cur_row_q  <= cur_row_d;
      cur_col_q  <= cur_col_d;
      base_q     <= base_d;
      nscroll_q  <= nscroll_d;
      sweep_q    <= sweep_d;
      col_cnt_q  <= col_cnt_d;
      clr_emit_q <= clr_emit_d;
    end
  end

  // Payload held for the item in progress.
  always_ff @(posedge clk_i) begin
    nl_q     <= nl_d;
    char_q   <= char_d;
    wr_row_q <= wr_row_d;
    wr_col_q <= wr_col_d;
    rd_row_q <= rd_row_d;
    rd_col_q <= rd_col_d;
    rd_ok_q  <= rd_ok_d;
    pend_q   <= pend_d;
  end

  tcw_screen_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire

@@ rtl/core/text_console_writer_top.sv @@
`default_nettype none

// Channel   Direction  Handshake            Payload
// input     in         in_valid_i/in_stall_o   action_i, char_code_i, cell_row_i, cell_col_i
// result    out        out_valid_o/out_stall_i serial_valid_o .. last_o
// config    in         psel/penable/pwrite     paddr, pwdata, prdata (text color)
//
// A printed character is stored with one write; a newline gives two transfers
// on the result channel. Each scroll blanks one row (the screen is a ring of
// rows), a read addresses the store and then returns its registered data, and a
// clear screen sweeps all ROWS*COLS cells, one per cycle.
// After reset the same sweep of all ROWS*COLS cells runs before the first input transfer.
// A stalled result sits in the output register while the next input is taken.

module text_console_writer_top #(
  parameter int ROWS = tcw_pkg::ROWS_DEF,
  parameter int COLS = tcw_pkg::COLS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [tcw_pkg::ACTION_W-1:0]    action_i,
  input  wire logic [tcw_pkg::CHAR_W-1:0]      char_code_i,
  input  wire logic [tcw_pkg::CELL_ROW_W-1:0]  cell_row_i,
  input  wire logic [tcw_pkg::CELL_COL_W-1:0]  cell_col_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic                                 serial_valid_o,
  output logic      [tcw_pkg::CHAR_W-1:0]      serial_byte_o,
  output logic      [tcw_pkg::CHAR_W-1:0]      read_char_o,
  output logic      [tcw_pkg::COLOR_W-1:0]     read_color_o,
  output logic      [tcw_pkg::CUR_ROW_W-1:0]   cursor_row_o,
  output logic      [tcw_pkg::CUR_COL_W-1:0]   cursor_col_o,
  output logic                                 last_o,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [tcw_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [tcw_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [tcw_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                 pready
);
  import tcw_pkg::*;

  logic [COLOR_W-1:0] color_q;
  logic               out_valid_q, out_valid_d;
  tcw_result_t        out_q;
  tcw_result_t        res;
  logic               res_valid;
  logic               res_ready;
  logic               cfg_write;

  // Register port: text color is the only register.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr == REG_TEXT_COLOR);
  assign prdata    = (paddr == REG_TEXT_COLOR) ? APB_DATA_W'(color_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= TEXT_COLOR_RST;
    end else if (cfg_write) begin
      color_q <= pwdata[COLOR_W-1:0];
    end
  end

  tcw_ctrl #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .char_code_i  (char_code_i),
    .cell_row_i   (cell_row_i),
    .cell_col_i   (cell_col_i),
    .text_color_i (color_q),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  // Output register: loads whenever it is empty or its transfer completes.
  assign res_ready   = !out_valid_q || !out_stall_i;
  assign out_valid_d = res_ready ? res_valid : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign serial_valid_o = out_q.serial_valid;
  assign serial_byte_o  = out_q.serial_byte;
  assign read_char_o    = out_q.read_char;
  assign read_color_o   = out_q.read_color;
  assign cursor_row_o   = out_q.cursor_row;
  assign cursor_col_o   = out_q.cursor_col;
  assign last_o         = out_q.last;

endmodule

`default_nettype wire
